[rtl/core/zrh_pkg.sv]
// zrh_pkg: widths, codes and shared types of the zero-run huffman encoder
// no dependencies; imported by the channel interfaces and the top level
package zrh_pkg;

   localparam int IDX_W  = 9;   // table slot field
   localparam int CODE_W = 32;  // code bits field
   localparam int LEN_W  = 6;   // code length field
   localparam int BYTE_W = 8;   // data and packed bytes
   localparam int CNT_W  = 19;  // packed byte count of a block
   localparam int OFF_W  = 14;  // widest run offset
   localparam int OFFL_W = 4;   // holds an offset length up to 14

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_ENCODE = 1'b1;

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_SUM  = 1'b1;

   // run symbol slots
   localparam logic [IDX_W-1:0] SYM_ZERO  = 9'd0;
   localparam logic [IDX_W-1:0] SYM_TWO   = 9'd256;
   localparam logic [IDX_W-1:0] SYM_UP6   = 9'd257;
   localparam logic [IDX_W-1:0] SYM_UP22  = 9'd258;
   localparam logic [IDX_W-1:0] SYM_UP278 = 9'd259;
   localparam logic [IDX_W-1:0] SYM_LONG  = 9'd260;

   // run class limits and offset bases
   localparam int RUN_TOP6   = 6;
   localparam int RUN_TOP22  = 22;
   localparam int RUN_TOP278 = 278;
   localparam int BASE_UP6   = 3;
   localparam int BASE_UP22  = 7;
   localparam int BASE_UP278 = 23;
   localparam int BASE_LONG  = 279;

   localparam logic [OFFL_W-1:0] OFFL_UP6   = 4'd2;
   localparam logic [OFFL_W-1:0] OFFL_UP22  = 4'd4;
   localparam logic [OFFL_W-1:0] OFFL_UP278 = 4'd8;
   localparam logic [OFFL_W-1:0] OFFL_LONG  = 4'd14;

   localparam logic [CNT_W-1:0] COUNT_MAX = '1;

   // one queued job for the table/accumulator engine
   typedef struct packed {
      logic                 is_load;
      logic                 load_ok;
      logic [IDX_W-1:0]     index;
      logic [CODE_W-1:0]    code;
      logic [LEN_W-1:0]     length;
      logic                 has_run;
      logic [IDX_W-1:0]     run_sym;
      logic [OFF_W-1:0]     off_val;
      logic [OFFL_W-1:0]    off_len;
      logic                 has_byte;
      logic [BYTE_W-1:0]    data_byte;
      logic                 blk_end;
   } zrh_job_type;

   // one result word without its last flag
   typedef struct packed {
      logic              kind;
      logic [BYTE_W-1:0] packed_byte;
      logic [CNT_W-1:0]  block_bytes;
   } zrh_res_type;

endpackage

[rtl/core/zrh_req_if.sv]
// zrh_req_if: input channel of the zero-run huffman encoder
// depends on zrh_pkg for field widths
interface zrh_req_if import zrh_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              op;
   logic [IDX_W-1:0]  entry_index;
   logic [CODE_W-1:0] entry_code;
   logic [LEN_W-1:0]  entry_length;
   logic [BYTE_W-1:0] data_byte;
   logic              block_end;

   modport source (output valid, op, entry_index, entry_code, entry_length, data_byte,
                   block_end, input ready);
   modport sink (input valid, op, entry_index, entry_code, entry_length, data_byte,
                 block_end, output ready);
endinterface

[rtl/core/zrh_rsp_if.sv]
// zrh_rsp_if: result channel of the zero-run huffman encoder
// depends on zrh_pkg for field widths
interface zrh_rsp_if import zrh_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              kind;
   logic [BYTE_W-1:0] packed_byte;
   logic [CNT_W-1:0]  block_bytes;
   logic              last;

   modport source (output valid, kind, packed_byte, block_bytes, last, input ready);
   modport sink (input valid, kind, packed_byte, block_bytes, last, output ready);
endinterface

[rtl/core/zero_run_huffman_encoder.sv]
// work per word: a word that emits no byte needs one table read and one append;
//   each code costs one read on the single table port and one append, and each
//   packed byte one drain of the shared accumulator; a block end adds pad and summary;
// the one-deep queue takes the next word while the engine works on the current one;
// results: a word's last result is held until its work is done so it can be flagged
// reset: synchronous, clears run count, accumulator, byte count and all valids;
//   the code table is not cleared and must be loaded before use
module zero_run_huffman_encoder import zrh_pkg::*; #(
   parameter int TABLE_SLOTS   = 261,
   parameter int MAX_CODE_BITS = 32,
   parameter int MAX_RUN       = 16662
) (
   input logic      clock,
   input logic      reset,
   zrh_req_if.sink  req_ch,
   zrh_rsp_if.source rsp_ch
);

   localparam int AW     = $clog2(TABLE_SLOTS);
   localparam int IDXC_W = AW + 1;
   localparam int RUN_W  = $clog2(MAX_RUN + 1);
   localparam int ACC_W  = MAX_CODE_BITS + 8;
   localparam int FILL_W = $clog2(ACC_W + 1);
   localparam int ENT_W  = CODE_W + LEN_W;

   // engine states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_RUNC  = 3'd1;
   localparam logic [2:0] ST_OFF   = 3'd2;
   localparam logic [2:0] ST_BYTEC = 3'd3;
   localparam logic [2:0] ST_PAD   = 3'd4;
   localparam logic [2:0] ST_SUM   = 3'd5;
   localparam logic [2:0] ST_FIN   = 3'd6;

   // code table: one write or one read port a cycle, registered read data
   logic [ENT_W-1:0] code_mem [TABLE_SLOTS];
   logic [ENT_W-1:0] rd_data_ff;
   logic             rd_en;
   logic [AW-1:0]    rd_addr;
   logic             wr_en;

   // front: run counting and the one-deep job queue
   logic [RUN_W-1:0] run_ff, run_in;
   logic             pend_vld_ff, pend_vld_in;
   zrh_job_type      pend_ff, pend_in;
   logic             pend_take;
   logic             req_accept;

   // engine
   logic [2:0]        st_ff, st_in;
   zrh_job_type       job_ff, job_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   // result path: hold stage keeps the newest result until its last flag is known
   logic        hold_vld_ff, hold_vld_in;
   zrh_res_type hold_ff, hold_in;
   logic        out_vld_ff, out_vld_in;
   zrh_res_type out_ff, out_in;
   logic        out_last_ff, out_last_in;
   logic        out_free;
   logic        emit_ok;
   logic        new_vld;
   zrh_res_type new_res;
   logic        flush;

   assign req_accept   = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !pend_vld_ff || pend_take;

   assign out_free = !out_vld_ff || rsp_ch.ready;
   assign emit_ok  = !hold_vld_ff || out_free;

   // ---------------------------------------------------------------------------
   // front: decide at accept time which run closes and how it is coded
   // ---------------------------------------------------------------------------
   always_comb begin
      logic             is_zero;
      logic [RUN_W-1:0] cnt1;
      logic             close_zero;
      logic [RUN_W-1:0] run_n;
      zrh_job_type      job;

      is_zero    = (req_ch.data_byte == '0);
      cnt1       = run_ff + RUN_W'(1);
      close_zero = is_zero && ((cnt1 >= RUN_W'(MAX_RUN)) || req_ch.block_end);
      // a nonzero byte closes the pending run; a zero closes it only at the limit or at block end
      run_n      = is_zero ? (close_zero ? cnt1 : '0) : run_ff;

      job           = '0;
      job.is_load   = (req_ch.op == OP_LOAD);
      job.load_ok   = (IDXC_W'(req_ch.entry_index) < IDXC_W'(TABLE_SLOTS));
      job.index     = req_ch.entry_index;
      job.code      = req_ch.entry_code;
      job.length    = req_ch.entry_length;
      job.has_run   = (run_n != '0);
      job.has_byte  = !is_zero;
      job.data_byte = req_ch.data_byte;
      job.blk_end   = req_ch.block_end;

      // run class: symbol slot plus offset bits
      if (run_n == RUN_W'(1)) begin
         job.run_sym = SYM_ZERO;
      end else if (run_n == RUN_W'(2)) begin
         job.run_sym = SYM_TWO;
      end else if (run_n <= RUN_W'(RUN_TOP6)) begin
         job.run_sym = SYM_UP6;
         job.off_val = OFF_W'(run_n - RUN_W'(BASE_UP6));
         job.off_len = OFFL_UP6;
      end else if (run_n <= RUN_W'(RUN_TOP22)) begin
         job.run_sym = SYM_UP22;
         job.off_val = OFF_W'(run_n - RUN_W'(BASE_UP22));
         job.off_len = OFFL_UP22;
      end else if (run_n <= RUN_W'(RUN_TOP278)) begin
         job.run_sym = SYM_UP278;
         job.off_val = OFF_W'(run_n - RUN_W'(BASE_UP278));
         job.off_len = OFFL_UP278;
      end else begin
         job.run_sym = SYM_LONG;
         job.off_val = OFF_W'(run_n - RUN_W'(BASE_LONG));
         job.off_len = OFFL_LONG;
      end

      run_in = run_ff;
      if (req_accept && !job.is_load) begin
         run_in = (is_zero && !close_zero) ? cnt1 : '0;
      end

      pend_in     = req_accept ? job : pend_ff;
      pend_vld_in = req_accept || (pend_vld_ff && !pend_take);
   end

   // ---------------------------------------------------------------------------
   // engine: table lookups, bit packing and byte drain, all through one sequencer
   // loads run through the same queue, so a table write never passes an earlier
   // word's read; a read in the cycle after a write sees the new entry
   // ---------------------------------------------------------------------------
   always_comb begin
      logic [CODE_W-1:0]        rd_code;
      logic [LEN_W-1:0]         rd_len;
      logic [MAX_CODE_BITS-1:0] ap_raw;
      logic [LEN_W-1:0]         ap_len;
      logic [MAX_CODE_BITS-1:0] ap_bits;
      logic [FILL_W-1:0]        fill_ap;
      logic [ACC_W-1:0]         acc_ap;
      logic                     has_room;
      logic                     fin_direct;
      logic [2:0]               after_run_st;
      logic                     after_run_rd;
      logic [2:0]               after_byte_st;
      logic                     drain_go;

      {rd_code, rd_len} = rd_data_ff;

      // what gets appended this cycle: a table code, or the run offset
      if (st_ff == ST_OFF) begin
         ap_raw = MAX_CODE_BITS'(job_ff.off_val);
         ap_len = LEN_W'(job_ff.off_len);
      end else begin
         ap_raw = rd_code[MAX_CODE_BITS-1:0];
         // over-long lengths saturate
         ap_len = (rd_len > LEN_W'(MAX_CODE_BITS)) ? LEN_W'(MAX_CODE_BITS) : rd_len;
      end
      ap_bits  = ap_raw & ~({MAX_CODE_BITS{1'b1}} << ap_len);
      fill_ap  = fill_ff + FILL_W'(ap_len);
      acc_ap   = acc_ff | (ACC_W'(ap_bits) << fill_ff);
      has_room = (fill_ff < FILL_W'(8));

      // word is done right after this append if no byte is left and nothing is held
      fin_direct = (fill_ap < FILL_W'(8)) && !hold_vld_ff;

      after_run_rd = 1'b0;
      if (job_ff.has_byte) begin
         after_run_st = ST_BYTEC;
         after_run_rd = 1'b1;
      end else if (job_ff.blk_end) begin
         after_run_st = ST_PAD;
      end else if (fin_direct) begin
         after_run_st = ST_IDLE;
      end else begin
         after_run_st = ST_FIN;
      end

      if (job_ff.blk_end) begin
         after_byte_st = ST_PAD;
      end else if (fin_direct) begin
         after_byte_st = ST_IDLE;
      end else begin
         after_byte_st = ST_FIN;
      end

      st_in     = st_ff;
      job_in    = job_ff;
      acc_in    = acc_ff;
      fill_in   = fill_ff;
      cnt_in    = cnt_ff;
      pend_take = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = AW'(job_ff.data_byte);
      wr_en     = 1'b0;
      new_vld   = 1'b0;
      new_res   = '0;
      flush     = 1'b0;
      drain_go  = 1'b0;

      case (st_ff)
         ST_IDLE: begin
            if (pend_vld_ff) begin
               pend_take = 1'b1;
               if (pend_ff.is_load) begin
                  // out-of-range slots are dropped
                  wr_en = pend_ff.load_ok;
               end else begin
                  job_in = pend_ff;
                  if (pend_ff.has_run) begin
                     rd_en   = 1'b1;
                     rd_addr = AW'(pend_ff.run_sym);
                     st_in   = ST_RUNC;
                  end else if (pend_ff.has_byte) begin
                     rd_en   = 1'b1;
                     rd_addr = AW'(pend_ff.data_byte);
                     st_in   = ST_BYTEC;
                  end else if (pend_ff.blk_end) begin
                     st_in = ST_PAD;
                  end
                  // else: a zero that only extends the run, nothing to do
               end
            end
         end
         ST_RUNC: begin
            if (!has_room) begin
               drain_go = 1'b1;
            end else begin
               acc_in  = acc_ap;
               fill_in = fill_ap;
               if (job_ff.off_len != '0) begin
                  st_in = ST_OFF;
               end else begin
                  st_in = after_run_st;
                  rd_en = after_run_rd;
               end
            end
         end
         ST_OFF: begin
            if (!has_room) begin
               drain_go = 1'b1;
            end else begin
               acc_in  = acc_ap;
               fill_in = fill_ap;
               st_in   = after_run_st;
               rd_en   = after_run_rd;
            end
         end
         ST_BYTEC: begin
            if (!has_room) begin
               drain_go = 1'b1;
            end else begin
               acc_in  = acc_ap;
               fill_in = fill_ap;
               st_in   = after_byte_st;
            end
         end
         ST_PAD: begin
            if (!has_room) begin
               drain_go = 1'b1;
            end else if (fill_ff == '0) begin
               // empty tail: no pad byte
               st_in = ST_SUM;
            end else if (emit_ok) begin
               new_vld             = 1'b1;
               new_res.kind        = KIND_BYTE;
               new_res.packed_byte = acc_ff[BYTE_W-1:0];
               cnt_in              = (cnt_ff == COUNT_MAX) ? cnt_ff : cnt_ff + CNT_W'(1);
               acc_in              = '0;
               fill_in             = '0;
               st_in               = ST_SUM;
            end
         end
         ST_SUM: begin
            if (emit_ok) begin
               new_vld             = 1'b1;
               new_res.kind        = KIND_SUM;
               new_res.block_bytes = cnt_ff;
               acc_in              = '0;
               fill_in             = '0;
               cnt_in              = '0;
               st_in               = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!has_room) begin
               drain_go = 1'b1;
            end else if (!hold_vld_ff) begin
               st_in = ST_IDLE;
            end else if (out_free) begin
               // release the held result as the word's last
               flush = 1'b1;
               st_in = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase

      // one whole byte leaves the accumulator
      if (drain_go && emit_ok) begin
         new_vld             = 1'b1;
         new_res.kind        = KIND_BYTE;
         new_res.packed_byte = acc_ff[BYTE_W-1:0];
         acc_in              = acc_ff >> 8;
         fill_in             = fill_ff - FILL_W'(8);
         cnt_in              = (cnt_ff == COUNT_MAX) ? cnt_ff : cnt_ff + CNT_W'(1);
      end
   end

   // ---------------------------------------------------------------------------
   // result path: hold stage then output register
   // ---------------------------------------------------------------------------
   always_comb begin
      hold_in     = hold_ff;
      hold_vld_in = hold_vld_ff;
      out_in      = out_ff;
      out_last_in = out_last_ff;
      out_vld_in  = out_vld_ff && !rsp_ch.ready;

      if (new_vld) begin
         // a newer result exists, so the held one is not the last
         if (hold_vld_ff) begin
            out_in      = hold_ff;
            out_last_in = 1'b0;
            out_vld_in  = 1'b1;
         end
         hold_in     = new_res;
         hold_vld_in = 1'b1;
      end else if (flush) begin
         out_in      = hold_ff;
         out_last_in = 1'b1;
         out_vld_in  = 1'b1;
         hold_vld_in = 1'b0;
      end
   end

   assign rsp_ch.valid       = out_vld_ff;
   assign rsp_ch.kind        = out_ff.kind;
   assign rsp_ch.packed_byte = out_ff.packed_byte;
   assign rsp_ch.block_bytes = out_ff.block_bytes;
   assign rsp_ch.last        = out_last_ff;

   // ---------------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (wr_en) begin
         code_mem[pend_ff.index[AW-1:0]] <= {pend_ff.code, pend_ff.length};
      end
      if (rd_en) begin
         rd_data_ff <= code_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff       <= ST_IDLE;
         run_ff      <= '0;
         pend_vld_ff <= 1'b0;
         acc_ff      <= '0;
         fill_ff     <= '0;
         cnt_ff      <= '0;
         hold_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         st_ff       <= st_in;
         run_ff      <= run_in;
         pend_vld_ff <= pend_vld_in;
         acc_ff      <= acc_in;
         fill_ff     <= fill_in;
         cnt_ff      <= cnt_in;
         hold_vld_ff <= hold_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      job_ff      <= job_in;
      hold_ff     <= hold_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   // ---------------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------------
   // between words nothing is held back and no whole byte is left unsent
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_IDLE) |-> (!hold_vld_ff && (fill_ff < FILL_W'(8))))
      else $error("engine idle with a held result or a whole byte pending");

   // a block summary always closes its word
   a_sum_last: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && (out_ff.kind == KIND_SUM)) |-> out_last_ff)
      else $error("summary result without last flag");

   // the accumulator never overflows
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff < FILL_W'(ACC_W))
      else $error("bit accumulator overflow");

   // a new result never overwrites a held one while the output is stalled
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (new_vld && hold_vld_ff) |-> out_free)
      else $error("result lost in the hold stage");

endmodule
